// ===== src/psn_pkg.sv =====
// package for the photometric stereo normal block
// shared types, constants and register indexes; no dependencies
`default_nettype none
package psn_pkg;
    localparam int MAX_LANES = 8;
    localparam int DEF_NUM_LIGHTS = 4;
    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ONE_Q14 = 16384;
    // vector component: 8 lanes of 16x8 signed products plus growth
    localparam int V_W = 28;
    // sum of squares of three components
    localparam int S_W = 56;
    localparam int L_W = 28;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] intensity_7;
        logic [7:0] intensity_6;
        logic [7:0] intensity_5;
        logic [7:0] intensity_4;
        logic [7:0] intensity_3;
        logic [7:0] intensity_2;
        logic [7:0] intensity_1;
        logic [7:0] intensity_0;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        albedo;
        logic signed [15:0] grad_p;
        logic signed [15:0] grad_q;
    } t_out_item;

    // request between front and back: the light vector
    typedef struct packed {
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
    } t_vec;
endpackage
`default_nettype wire

// ===== src/psn_front.sv =====
// front end: coefficient registers and the 3 x N matrix-vector product
// depends on psn_pkg
`default_nettype none
module psn_front
    import psn_pkg::*;
#(
    parameter int NUM_LIGHTS = DEF_NUM_LIGHTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_in_item              i_item,
    output logic                       o_valid,
    output t_vec                       o_vec
);
    logic [CFG_DATA_W-1:0] r_coef [NUM_REGS];
    logic [7:0]  w_lane [MAX_LANES];
    logic signed [V_W-1:0] r_prod [3][MAX_LANES];
    logic r_v1, r_v2;
    t_vec r_vec;

    assign w_lane[0] = i_item.intensity_0;
    assign w_lane[1] = i_item.intensity_1;
    assign w_lane[2] = i_item.intensity_2;
    assign w_lane[3] = i_item.intensity_3;
    assign w_lane[4] = i_item.intensity_4;
    assign w_lane[5] = i_item.intensity_5;
    assign w_lane[6] = i_item.intensity_6;
    assign w_lane[7] = i_item.intensity_7;

    // register writes; out of range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_coef[k] <= '0;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stage one: one product per row and lane, unused lanes zero
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int l = 0; l < MAX_LANES; l++) begin
                if (l < NUM_LIGHTS) begin
                    r_prod[r][l] <= V_W'($signed(r_coef[r*2 + l/4][16*(l%4) +: 16])
                                    * $signed({1'b0, w_lane[l]}));
                end else begin
                    r_prod[r][l] <= '0;
                end
            end
        end
    end

    // stage two: lane sums
    always_ff @(posedge i_clk) begin
        logic signed [V_W-1:0] a [3];
        for (int r = 0; r < 3; r++) begin
            a[r] = '0;
            for (int l = 0; l < MAX_LANES; l++) a[r] = a[r] + r_prod[r][l];
        end
        r_vec.vx <= a[0];
        r_vec.vy <= a[1];
        r_vec.vz <= a[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_vec;
endmodule
`default_nettype wire

// ===== src/psn_queue.sv =====
// short request queue between front and back
// depends on psn_pkg
`default_nettype none
module psn_queue
    import psn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_vec i_data,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_vec      o_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    t_vec r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop && o_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && o_valid);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

// ===== src/psn_back.sv =====
// back end: pipelined square root, normalization, gradients
// depends on psn_pkg
`default_nettype none
module psn_back
    import psn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_vec i_vec,
    output logic      o_valid,
    output t_out_item o_item
);
    // square root: one result bit per stage
    localparam int SQ_ST = L_W;
    // restoring divider for normals: 16 quotient bits plus sign room
    localparam int NQ_W = 17;
    // gradient divider quotient bits
    localparam int GQ_W = 24;
    localparam int NN_W = V_W + 16;   // |v| * 2^15 numerator
    localparam int GN_W = 24;         // |n| * 512 numerator
    // ceil(2^32 / 255), exact for the quotient range used here
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    // ---------------- stage A: magnitudes and sum of squares
    logic          r_a_v;
    logic [S_W-1:0] r_a_s;
    logic [V_W-1:0] r_a_m [3];
    logic [2:0]     r_a_neg;
    always_ff @(posedge i_clk) begin
        logic [V_W-1:0] m [3];
        m[0] = i_vec.vx[V_W-1] ? V_W'(-i_vec.vx) : V_W'(i_vec.vx);
        m[1] = i_vec.vy[V_W-1] ? V_W'(-i_vec.vy) : V_W'(i_vec.vy);
        m[2] = i_vec.vz[V_W-1] ? V_W'(-i_vec.vz) : V_W'(i_vec.vz);
        for (int c = 0; c < 3; c++) r_a_m[c] <= m[c];
        r_a_neg <= {i_vec.vz[V_W-1], i_vec.vy[V_W-1], i_vec.vx[V_W-1]};
        r_a_s   <= S_W'(m[0] * m[0]) + S_W'(m[1] * m[1]) + S_W'(m[2] * m[2]);
    end

    // ---------------- square root pipeline
    logic           r_q_v   [SQ_ST+1];
    logic [S_W-1:0] r_q_rem [SQ_ST+1];
    logic [L_W-1:0] r_q_res [SQ_ST+1];
    logic [V_W-1:0] r_q_m   [SQ_ST+1][3];
    logic [2:0]     r_q_neg [SQ_ST+1];
    always_comb begin
        r_q_v[0]   = r_a_v;
        r_q_rem[0] = r_a_s;
        r_q_res[0] = '0;
        r_q_m[0]   = r_a_m;
        r_q_neg[0] = r_a_neg;
    end
    for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
        localparam int B = SQ_ST - 1 - g;
        always_ff @(posedge i_clk) begin
            logic [S_W+1:0] trial;
            trial = ({2'b0, S_W'(r_q_res[g])} << (B + 1)) + ((S_W+2)'(1) << (2*B));
            if ({2'b0, r_q_rem[g]} >= trial) begin
                r_q_rem[g+1] <= S_W'({2'b0, r_q_rem[g]} - trial);
                r_q_res[g+1] <= r_q_res[g] | (L_W'(1) << B);
            end else begin
                r_q_rem[g+1] <= r_q_rem[g];
                r_q_res[g+1] <= r_q_res[g];
            end
            r_q_m[g+1]   <= r_q_m[g];
            r_q_neg[g+1] <= r_q_neg[g];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            for (int k = 1; k <= SQ_ST; k++) r_q_v[k] <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            for (int k = 1; k <= SQ_ST; k++) r_q_v[k] <= r_q_v[k-1];
        end
    end

    // ---------------- albedo: round(L/4080) = ((L + 2040) / 16) / 255
    // the divide by 255 is a reciprocal multiply; L < 2^27 keeps it exact
    // and the quotient well inside 16 bits, so no saturation guard
    // ---------------- normal dividers: q = (2*|v|*2^14 + L) / (2L)
    localparam int ND_ST = NQ_W;
    logic           r_d_v    [ND_ST+1];
    logic [NN_W:0]  r_d_rem  [ND_ST+1][3];
    logic [NQ_W-1:0] r_d_q   [ND_ST+1][3];
    logic [NN_W:0]  r_d_den  [ND_ST+1][3];
    logic [2:0]     r_d_neg  [ND_ST+1];
    logic           r_d_zero [ND_ST+1];
    logic [15:0]    r_d_alb  [ND_ST+1];
    always_comb begin
        logic [L_W-1:0] l;
        logic [L_W:0]   anum;
        logic [49:0]    aprod;
        l = r_q_res[SQ_ST];
        anum  = (L_W+1)'(l) + (L_W+1)'(2040);
        aprod = 50'(anum[L_W:4]) * 50'(RECIP_255);
        r_d_v[0]    = r_q_v[SQ_ST];
        r_d_neg[0]  = r_q_neg[SQ_ST];
        r_d_zero[0] = (l == '0);
        r_d_alb[0]  = 16'(aprod >> 32);
        for (int c = 0; c < 3; c++) begin
            r_d_rem[0][c] = (NN_W+1)'({r_q_m[SQ_ST][c], 15'b0}) + (NN_W+1)'(l);
            r_d_den[0][c] = (NN_W+1)'({l, 1'b0});
            r_d_q[0][c]   = '0;
        end
    end
    for (genvar g = 0; g < ND_ST; g++) begin : g_ndiv
        localparam int B = ND_ST - 1 - g;
        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                logic [2*NN_W+1:0] sh;
                sh = (2*NN_W+2)'(r_d_den[g][c]) << B;
                if ((2*NN_W+2)'(r_d_rem[g][c]) >= sh) begin
                    r_d_rem[g+1][c] <= r_d_rem[g][c] - (NN_W+1)'(sh);
                    r_d_q[g+1][c]   <= r_d_q[g][c] | (NQ_W'(1) << B);
                end else begin
                    r_d_rem[g+1][c] <= r_d_rem[g][c];
                    r_d_q[g+1][c]   <= r_d_q[g][c];
                end
                r_d_den[g+1][c] <= r_d_den[g][c];
            end
            r_d_neg[g+1]  <= r_d_neg[g];
            r_d_zero[g+1] <= r_d_zero[g];
            r_d_alb[g+1]  <= r_d_alb[g];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= ND_ST; k++) r_d_v[k] <= 1'b0;
        end else begin
            for (int k = 1; k <= ND_ST; k++) r_d_v[k] <= r_d_v[k-1];
        end
    end

    // ---------------- clamp normals, fix z, set up gradient divides
    logic        r_n_v;
    logic [15:0] r_n_mz;
    logic        r_n_negz;
    logic signed [15:0] r_n_x, r_n_y, r_n_z;
    logic [15:0] r_n_alb;
    always_ff @(posedge i_clk) begin
        logic [NQ_W-1:0] m [3];
        logic [15:0] mz;
        logic signed [15:0] s [3];
        for (int c = 0; c < 3; c++) begin
            m[c] = r_d_zero[ND_ST] ? '0 :
                   (r_d_q[ND_ST][c] > NQ_W'(ONE_Q14) ? NQ_W'(ONE_Q14) : r_d_q[ND_ST][c]);
            s[c] = r_d_neg[ND_ST][c] ? -16'(m[c]) : 16'(m[c]);
        end
        mz = (m[2] == '0) ? 16'(ONE_Q14) : 16'(m[2]);
        r_n_x    <= s[0];
        r_n_y    <= s[1];
        r_n_z    <= (m[2] == '0) ? 16'(ONE_Q14) : s[2];
        r_n_mz   <= mz;
        r_n_negz <= (m[2] != '0) && r_d_neg[ND_ST][2];
        r_n_alb  <= r_d_alb[ND_ST];
    end
    // magnitudes of x and y for the gradient dividers
    logic [15:0] r_n_ax, r_n_ay;
    always_ff @(posedge i_clk) begin
        r_n_ax <= r_d_zero[ND_ST] ? '0 :
                  16'(r_d_q[ND_ST][0] > NQ_W'(ONE_Q14) ? NQ_W'(ONE_Q14) : r_d_q[ND_ST][0]);
        r_n_ay <= r_d_zero[ND_ST] ? '0 :
                  16'(r_d_q[ND_ST][1] > NQ_W'(ONE_Q14) ? NQ_W'(ONE_Q14) : r_d_q[ND_ST][1]);
    end

    // ---------------- gradient dividers: (2*|n|*256 + |z|) / (2|z|)
    localparam int GD_ST = GQ_W;
    logic            r_g_v   [GD_ST+1];
    logic [GN_W+1:0] r_g_rem [GD_ST+1][2];
    logic [GQ_W-1:0] r_g_q   [GD_ST+1][2];
    logic [16:0]     r_g_den [GD_ST+1];
    logic [1:0]      r_g_neg [GD_ST+1];
    t_out_item       r_g_pl  [GD_ST+1];
    always_comb begin
        r_g_v[0]      = r_n_v;
        r_g_den[0]    = {r_n_mz, 1'b0};
        r_g_rem[0][0] = (GN_W+2)'({r_n_ax, 9'b0}) + (GN_W+2)'(r_n_mz);
        r_g_rem[0][1] = (GN_W+2)'({r_n_ay, 9'b0}) + (GN_W+2)'(r_n_mz);
        r_g_q[0][0]   = '0;
        r_g_q[0][1]   = '0;
        r_g_neg[0]    = {(r_n_ay != '0) & (r_n_y[15] ^ r_n_negz),
                         (r_n_ax != '0) & (r_n_x[15] ^ r_n_negz)};
        r_g_pl[0]          = '0;
        r_g_pl[0].normal_x = r_n_x;
        r_g_pl[0].normal_y = r_n_y;
        r_g_pl[0].normal_z = r_n_z;
        r_g_pl[0].albedo   = r_n_alb;
    end
    for (genvar g = 0; g < GD_ST; g++) begin : g_gdiv
        localparam int B = GD_ST - 1 - g;
        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 2; c++) begin
                logic [GN_W+GQ_W+1:0] sh;
                sh = (GN_W+GQ_W+2)'(r_g_den[g]) << B;
                if ((GN_W+GQ_W+2)'(r_g_rem[g][c]) >= sh) begin
                    r_g_rem[g+1][c] <= r_g_rem[g][c] - (GN_W+2)'(sh);
                    r_g_q[g+1][c]   <= r_g_q[g][c] | (GQ_W'(1) << B);
                end else begin
                    r_g_rem[g+1][c] <= r_g_rem[g][c];
                    r_g_q[g+1][c]   <= r_g_q[g][c];
                end
            end
            r_g_den[g+1] <= r_g_den[g];
            r_g_neg[g+1] <= r_g_neg[g];
            r_g_pl[g+1]  <= r_g_pl[g];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
            for (int k = 1; k <= GD_ST; k++) r_g_v[k] <= 1'b0;
        end else begin
            r_n_v <= r_d_v[ND_ST];
            for (int k = 1; k <= GD_ST; k++) r_g_v[k] <= r_g_v[k-1];
        end
    end

    // ---------------- output register with saturation
    logic      r_o_v;
    t_out_item r_o_item;
    always_ff @(posedge i_clk) begin
        t_out_item it;
        it = r_g_pl[GD_ST];
        if (r_g_neg[GD_ST][0])
            it.grad_p = (r_g_q[GD_ST][0] > GQ_W'(32768)) ? 16'sh8000
                        : -16'(r_g_q[GD_ST][0]);
        else
            it.grad_p = (r_g_q[GD_ST][0] > GQ_W'(32767)) ? 16'sh7fff
                        : 16'(r_g_q[GD_ST][0]);
        if (r_g_neg[GD_ST][1])
            it.grad_q = (r_g_q[GD_ST][1] > GQ_W'(32768)) ? 16'sh8000
                        : -16'(r_g_q[GD_ST][1]);
        else
            it.grad_q = (r_g_q[GD_ST][1] > GQ_W'(32767)) ? 16'sh7fff
                        : 16'(r_g_q[GD_ST][1]);
        r_o_item <= it;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else          r_o_v <= r_g_v[GD_ST];
    end

    assign o_valid = r_o_v;
    assign o_item  = r_o_item;
endmodule
`default_nettype wire

// ===== src/photometric_stereo_normal.sv =====
// top level of the photometric stereo normal block
// depends on psn_pkg, psn_front, psn_queue, psn_back
//
// One pixel is taken in every cycle (start while busy is low; busy
// stays low) and its result passes through the bit-per-stage square
// root and the two bit-per-stage divider pipelines; the receiver cannot
// stall, so each o_done pulse must be captured in its cycle. The user is
// to write coefficient registers through the plain write port only while
// the block is idle; the block itself does not enforce it.
`default_nettype none
module photometric_stereo_normal
    import psn_pkg::*;
#(
    parameter int NUM_LIGHTS = DEF_NUM_LIGHTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  start,
    input  wire t_in_item              i_item,
    output logic                       busy,
    output logic                       o_done,
    output t_out_item                  o_item
);
    logic w_fv, w_qv;
    t_vec w_fvec, w_qvec;

    assign busy = 1'b0;

    psn_front #(.NUM_LIGHTS(NUM_LIGHTS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(start && !busy), .i_item,
        .o_valid(w_fv), .o_vec(w_fvec)
    );

    // back end never stalls, so every queued request is popped at once
    psn_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_fv), .i_data(w_fvec),
        .i_pop(1'b1), .o_valid(w_qv), .o_data(w_qvec)
    );

    psn_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .i_vec(w_qvec),
        .o_valid(o_done), .o_item
    );
endmodule
`default_nettype wire

// ===== src/psn_checker.sv =====
// port-level checks for the photometric stereo normal block
// depends on psn_pkg and photometric_stereo_normal
`default_nettype none
module psn_checker
    import psn_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      busy,
    input wire logic      o_done,
    input wire t_out_item o_item
);
    // block always ready
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    // normal z never zero on a result
    a_z_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_item.normal_z != 16'sd0)) else $error("normal_z zero");
    // normal x component in range
    a_nx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_item.normal_x <= 16'sd16384 && o_item.normal_x >= -16'sd16384))
        else $error("normal_x out of range");
    // no result in the cycle in which reset is released
    a_quiet: assert property (@(posedge i_clk) $rose(i_rst_n) |-> !o_done)
        else $error("result after reset");
endmodule

bind photometric_stereo_normal psn_checker u_psn_checker (
    .i_clk, .i_rst_n, .busy, .o_done, .o_item
);
`default_nettype wire
